// File: rtl/lsdc_pkg.sv
// Shared types and constants of the lane steering drive controller.
package lsdc_pkg;

  localparam int ERR_W      = 12;
  localparam int TIME_W     = 32;
  localparam int DUTY_W     = 20;
  localparam int THR_W      = 11;
  localparam int WIN_W      = 16;
  localparam int GAIN_W     = 10;
  localparam int GAIN_FRAC  = 8;
  localparam int PROD_W     = ERR_W + GAIN_W;
  localparam int OFFS_W     = PROD_W - GAIN_FRAC;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_DUTY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_DUTY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERROR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY      = 3'd7;

  // register values after reset
  localparam logic [THR_W-1:0]  RST_DEV_THRESHOLD = 11'd20;
  localparam logic [WIN_W-1:0]  RST_WINDOW_LIMIT  = 16'd500;
  localparam logic [DUTY_W-1:0] RST_CRUISE_DUTY   = 20'd200000;
  localparam logic [DUTY_W-1:0] RST_CORNER_DUTY   = 20'd140000;
  localparam logic [THR_W-1:0]  RST_MAX_ERROR     = 11'd100;
  localparam logic [GAIN_W-1:0] RST_STEER_GAIN    = 10'd179;
  localparam logic [DUTY_W-1:0] RST_MIN_DUTY      = 20'd120000;
  localparam logic [DUTY_W-1:0] RST_MAX_DUTY      = 20'd250000;

  typedef struct packed {
    logic signed [ERR_W-1:0] raw_error;
    logic [TIME_W-1:0]       frame_time_ms;
    logic                    lane_found;
  } lsdc_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
    logic                    drive_on;
    logic signed [ERR_W-1:0] smoothed_error;
    logic                    corner_mode;
  } lsdc_out_t;

endpackage

// File: rtl/lsdc_div.sv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
module lsdc_div #(
  parameter int DVD_W = 15,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  acc;        // dividend bits shift out, quotient bits shift in
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  divisor_r;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    trial_diff;
  logic              fits;
  logic [DVS_W-1:0]  rem_next;

  always_comb begin
    trial      = {rem, acc[DVD_W-1]};
    trial_diff = trial - {1'b0, divisor_r};
    fits       = (trial >= {1'b0, divisor_r});
    rem_next   = fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DVD_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc       <= dividend;
      rem       <= '0;
      divisor_r <= divisor;
    end else if (busy) begin
      acc <= {acc[DVD_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = acc;

endmodule

// File: rtl/lane_steering_drive_controller.sv
// Top level of the lane steering drive controller.
// Each accepted word carries one frame's signed raw lane error, a millisecond
// timestamp and a lane-found bit; each produces exactly one result word with the
// left and right duties, a drive-on bit, the smoothed error and the corner flag.
// On acceptance the error history (last AVG_DEPTH frames), the running sum, the
// timestamp history (last RUN_FRAMES frames), the deviation run and the corner
// flag are all updated together. The average is then formed by a
// bit-serial divider that produces one quotient bit per cycle over the magnitude
// of the sum, SUM_W = 12 + clog2(AVG_DEPTH) bits (15 at the default depth), so the
// divider sets the pace. The ST_SCALE step then scales the clamped error by the Q8
// gain, and the ST_DRIVE step forms and clamps the duties and loads the output
// register. in_ready is high only while the sequencer is idle. The output register
// holds its word until taken, and a new word is accepted while it waits; a word
// that reaches the last step while the previous result is still waiting holds
// there until the output register frees. Configuration writes are meant to be
// made only while the block is idle. Without a lane the duties and drive_on read
// zero, but the history, run and corner flag update as usual.
module lane_steering_drive_controller #(
  parameter int AVG_DEPTH  = 8,
  parameter int RUN_FRAMES = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  lsdc_pkg::lsdc_in_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output lsdc_pkg::lsdc_out_t                out_word,
  input  logic                               cfg_wr_en,
  input  logic [lsdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsdc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ERR_W  = lsdc_pkg::ERR_W;
  localparam int SUM_W  = ERR_W + $clog2(AVG_DEPTH);
  localparam int HCNT_W = $clog2(AVG_DEPTH + 1);
  localparam int TCNT_W = $clog2(RUN_FRAMES + 1);
  localparam int LR_W   = lsdc_pkg::DUTY_W + 2;   // signed room for speed +/- offset

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_DRIVE
  } state_t;

  // configuration registers
  logic [lsdc_pkg::THR_W-1:0]  dev_limit;
  logic [lsdc_pkg::WIN_W-1:0]  window_limit_ms;
  logic [lsdc_pkg::DUTY_W-1:0] cruise_duty;
  logic [lsdc_pkg::DUTY_W-1:0] corner_duty;
  logic [lsdc_pkg::THR_W-1:0]  max_error;
  logic [lsdc_pkg::GAIN_W-1:0] steer_gain;
  logic [lsdc_pkg::DUTY_W-1:0] min_duty;
  logic [lsdc_pkg::DUTY_W-1:0] max_duty;

  // frame history state
  logic signed [ERR_W-1:0]           err_hist      [AVG_DEPTH];
  logic signed [ERR_W-1:0]           err_hist_next [AVG_DEPTH];
  logic [HCNT_W-1:0]                 hist_count;
  logic [HCNT_W-1:0]                 hist_count_next;
  logic signed [SUM_W-1:0]           err_sum;
  logic signed [SUM_W-1:0]           err_sum_next;
  logic [lsdc_pkg::TIME_W-1:0]       time_hist      [RUN_FRAMES];
  logic [lsdc_pkg::TIME_W-1:0]       time_hist_next [RUN_FRAMES];
  logic [TCNT_W-1:0]                 time_count;
  logic [TCNT_W-1:0]                 time_count_next;
  logic [TCNT_W-1:0]                 dev_run;
  logic [TCNT_W-1:0]                 dev_run_next;
  logic                              corner_flag;
  logic                              corner_next;

  logic                              hist_full;
  logic                              time_full;
  logic [lsdc_pkg::TIME_W-1:0]       time_span;
  logic                              time_ok;
  logic [ERR_W-1:0]                  err_mag;
  logic                              deviating;
  logic [SUM_W-1:0]                  sum_mag;

  // sequencer and datapath registers
  state_t                            state;
  logic                              accept;
  logic                              lane_r;
  logic                              avg_neg;
  logic signed [ERR_W-1:0]           avg;
  logic [ERR_W-1:0]                  avg_mag;
  logic [lsdc_pkg::PROD_W-1:0]       prod;
  logic                              div_done;
  logic [SUM_W-1:0]                  div_quo;
  logic [ERR_W-1:0]                  quo_mag;
  logic [ERR_W-1:0]                  err_clamped;
  logic [lsdc_pkg::OFFS_W-1:0]       offs_mag;
  logic [lsdc_pkg::DUTY_W-1:0]       speed;
  logic signed [LR_W-1:0]            left_raw;
  logic signed [LR_W-1:0]            right_raw;
  logic signed [LR_W-1:0]            left_hi;
  logic signed [LR_W-1:0]            right_hi;
  logic [lsdc_pkg::DUTY_W-1:0]       left_duty;
  logic [lsdc_pkg::DUTY_W-1:0]       right_duty;
  logic                              out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration: one register per index, written in place.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_limit       <= lsdc_pkg::RST_DEV_THRESHOLD;
      window_limit_ms <= lsdc_pkg::RST_WINDOW_LIMIT;
      cruise_duty     <= lsdc_pkg::RST_CRUISE_DUTY;
      corner_duty     <= lsdc_pkg::RST_CORNER_DUTY;
      max_error       <= lsdc_pkg::RST_MAX_ERROR;
      steer_gain      <= lsdc_pkg::RST_STEER_GAIN;
      min_duty        <= lsdc_pkg::RST_MIN_DUTY;
      max_duty        <= lsdc_pkg::RST_MAX_DUTY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lsdc_pkg::CFG_DEV_THRESHOLD: dev_limit       <= cfg_data[lsdc_pkg::THR_W-1:0];
        lsdc_pkg::CFG_WINDOW_LIMIT:  window_limit_ms <= cfg_data[lsdc_pkg::WIN_W-1:0];
        lsdc_pkg::CFG_CRUISE_DUTY:   cruise_duty     <= cfg_data[lsdc_pkg::DUTY_W-1:0];
        lsdc_pkg::CFG_CORNER_DUTY:   corner_duty     <= cfg_data[lsdc_pkg::DUTY_W-1:0];
        lsdc_pkg::CFG_MAX_ERROR:     max_error       <= cfg_data[lsdc_pkg::THR_W-1:0];
        lsdc_pkg::CFG_STEER_GAIN:    steer_gain      <= cfg_data[lsdc_pkg::GAIN_W-1:0];
        lsdc_pkg::CFG_MIN_DUTY:      min_duty        <= cfg_data[lsdc_pkg::DUTY_W-1:0];
        lsdc_pkg::CFG_MAX_DUTY:      max_duty        <= cfg_data[lsdc_pkg::DUTY_W-1:0];
      endcase
    end
  end

  // Error history: fill from the bottom, then shift the oldest out at the
  // bottom and take the newest in at the top. The sum follows.
  always_comb begin
    hist_full = (hist_count == HCNT_W'(AVG_DEPTH));
    for (int i = 0; i < AVG_DEPTH - 1; i++) begin
      if (hist_full) begin
        err_hist_next[i] = err_hist[i+1];
      end else if (hist_count == HCNT_W'(i)) begin
        err_hist_next[i] = in_word.raw_error;
      end else begin
        err_hist_next[i] = err_hist[i];
      end
    end
    if (hist_full || hist_count == HCNT_W'(AVG_DEPTH - 1)) begin
      err_hist_next[AVG_DEPTH-1] = in_word.raw_error;
    end else begin
      err_hist_next[AVG_DEPTH-1] = err_hist[AVG_DEPTH-1];
    end
    hist_count_next = hist_full ? hist_count : hist_count + 1'b1;
    err_sum_next    = err_sum + SUM_W'(in_word.raw_error)
                      - (hist_full ? SUM_W'(err_hist[0]) : SUM_W'(0));
    sum_mag         = err_sum_next[SUM_W-1] ? SUM_W'(-err_sum_next) : SUM_W'(err_sum_next);
  end

  // Timestamp history and the span test over the newest RUN_FRAMES frames.
  always_comb begin
    time_full = (time_count == TCNT_W'(RUN_FRAMES));
    for (int i = 0; i < RUN_FRAMES - 1; i++) begin
      if (time_full) begin
        time_hist_next[i] = time_hist[i+1];
      end else if (time_count == TCNT_W'(i)) begin
        time_hist_next[i] = in_word.frame_time_ms;
      end else begin
        time_hist_next[i] = time_hist[i];
      end
    end
    if (time_full || time_count == TCNT_W'(RUN_FRAMES - 1)) begin
      time_hist_next[RUN_FRAMES-1] = in_word.frame_time_ms;
    end else begin
      time_hist_next[RUN_FRAMES-1] = time_hist[RUN_FRAMES-1];
    end
    time_count_next = time_full ? time_count : time_count + 1'b1;
    // wraps modulo 2^32 on purpose
    time_span       = in_word.frame_time_ms - time_hist_next[0];
    time_ok         = (time_count_next == TCNT_W'(RUN_FRAMES))
                      && (time_span <= lsdc_pkg::TIME_W'(window_limit_ms));
  end

  // Deviation run (saturating) and corner mode.
  always_comb begin
    err_mag   = in_word.raw_error[ERR_W-1] ? ERR_W'(-in_word.raw_error)
                                           : ERR_W'(in_word.raw_error);
    deviating = (err_mag > {1'b0, dev_limit});
    if (!deviating) begin
      dev_run_next = '0;
    end else if (dev_run == TCNT_W'(RUN_FRAMES)) begin
      dev_run_next = dev_run;
    end else begin
      dev_run_next = dev_run + 1'b1;
    end
    priority if (dev_run_next == TCNT_W'(RUN_FRAMES) && time_ok) begin
      corner_next = 1'b1;
    end else if (dev_run_next == '0) begin
      corner_next = 1'b0;
    end else begin
      corner_next = corner_flag;
    end
  end

  // Advance the history state once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_count  <= '0;
      err_sum     <= '0;
      time_count  <= '0;
      dev_run     <= '0;
      corner_flag <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        err_hist[i] <= '0;
      end
      for (int i = 0; i < RUN_FRAMES; i++) begin
        time_hist[i] <= '0;
      end
    end else if (accept) begin
      hist_count  <= hist_count_next;
      err_sum     <= err_sum_next;
      time_count  <= time_count_next;
      dev_run     <= dev_run_next;
      corner_flag <= corner_next;
      err_hist    <= err_hist_next;
      time_hist   <= time_hist_next;
    end
  end

  // Average: |sum| / count, one quotient bit per cycle, sign restored after.
  lsdc_div #(
    .DVD_W (SUM_W),
    .DVS_W (HCNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (sum_mag),
    .divisor  (hist_count_next),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Steering datapath between sequencer steps.
  always_comb begin
    quo_mag     = div_quo[ERR_W-1:0];
    err_clamped = (avg_mag > {1'b0, max_error}) ? {1'b0, max_error} : avg_mag;
    offs_mag    = prod[lsdc_pkg::PROD_W-1:lsdc_pkg::GAIN_FRAC];
    speed       = corner_flag ? corner_duty : cruise_duty;
    // offset is sign(avg) * offs_mag; left takes it away, right adds it
    if (avg_neg) begin
      left_raw  = $signed(LR_W'(speed)) + $signed(LR_W'(offs_mag));
      right_raw = $signed(LR_W'(speed)) - $signed(LR_W'(offs_mag));
    end else begin
      left_raw  = $signed(LR_W'(speed)) - $signed(LR_W'(offs_mag));
      right_raw = $signed(LR_W'(speed)) + $signed(LR_W'(offs_mag));
    end
    // upper clamp first, then lower, so min_duty wins when the limits cross
    left_hi  = (left_raw > $signed(LR_W'(max_duty))) ? $signed(LR_W'(max_duty)) : left_raw;
    right_hi = (right_raw > $signed(LR_W'(max_duty))) ? $signed(LR_W'(max_duty)) : right_raw;
    left_duty  = (left_hi < $signed(LR_W'(min_duty))) ? min_duty
                                                      : left_hi[lsdc_pkg::DUTY_W-1:0];
    right_duty = (right_hi < $signed(LR_W'(min_duty))) ? min_duty
                                                       : right_hi[lsdc_pkg::DUTY_W-1:0];
  end

  // Sequencer: accept, divide, scale, drive, then hold the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // raise on a fresh result word, drop once the old one is taken
      if (state == ST_DRIVE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state   <= ST_DIV;
            lane_r  <= in_word.lane_found;
            avg_neg <= err_sum_next[SUM_W-1];
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state   <= ST_SCALE;
            avg_mag <= quo_mag;
            avg     <= avg_neg ? $signed(-quo_mag) : $signed(quo_mag);
          end
        end
        ST_SCALE: begin
          state <= ST_DRIVE;
          prod  <= lsdc_pkg::PROD_W'(err_clamped) * lsdc_pkg::PROD_W'(steer_gain);
        end
        ST_DRIVE: begin
          if (out_free) begin
            state                   <= ST_IDLE;
            out_word.left_duty      <= lane_r ? left_duty : '0;
            out_word.right_duty     <= lane_r ? right_duty : '0;
            out_word.drive_on       <= lane_r;
            out_word.smoothed_error <= avg;
            out_word.corner_mode    <= corner_flag;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/lsdc_checker.sv
// Port-level checks on the lane steering drive controller, bound to its top level.
module lsdc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lsdc_pkg::lsdc_out_t out_word
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  // no lane: drive off and both duties zero
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.drive_on |->
      out_word.left_duty == '0 && out_word.right_duty == '0)
    else $error("non-zero duty with drive off");

  // one word at a time: busy right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after acceptance");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind lane_steering_drive_controller lsdc_checker u_lsdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the lane steering drive controller.
module tb_top;

  localparam int HIST_DEPTH   = 8;     // frames averaged for the smoothed error
  localparam int STREAK_LEN   = 5;     // deviating frames needed for corner mode
  localparam int DIR_N        = 22;    // rows in the directed table
  localparam int PHASES       = 9;     // random phases after the directed one
  localparam int PHASE_FRAMES = 192;   // random words per phase
  localparam int STALL_LIMIT  = 3000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 40;    // settle time after the last owed word

  // Register settings used across the phases.
  typedef enum int {SET_RESET, SET_HIGH, SET_LOW, SET_RANDOM} setting_t;

  // One directed row: the word to send and, where it is obvious, the word to expect.
  typedef struct packed {
    lsdc_pkg::lsdc_in_t  word;
    logic                fixed;
    lsdc_pkg::lsdc_out_t want;
  } dir_row_t;

  localparam lsdc_pkg::lsdc_out_t NO_WANT = '0;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  lsdc_pkg::lsdc_in_t              in_word = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  lsdc_pkg::lsdc_out_t             out_word;
  logic                            cfg_wr_en = 1'b0;
  logic [lsdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lsdc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Side band travelling with the word on the input channel.
  logic                word_fixed = 1'b0;
  lsdc_pkg::lsdc_out_t word_want = '0;

  lane_steering_drive_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the block: registers as last written and the frame history.
  // ---------------------------------------------------------------------------
  int thr_cfg    = int'(lsdc_pkg::RST_DEV_THRESHOLD);
  int win_cfg    = int'(lsdc_pkg::RST_WINDOW_LIMIT);
  int base_cfg   = int'(lsdc_pkg::RST_CRUISE_DUTY);
  int slow_cfg   = int'(lsdc_pkg::RST_CORNER_DUTY);
  int maxerr_cfg = int'(lsdc_pkg::RST_MAX_ERROR);
  int gain_cfg   = int'(lsdc_pkg::RST_STEER_GAIN);
  int mindut_cfg = int'(lsdc_pkg::RST_MIN_DUTY);
  int maxdut_cfg = int'(lsdc_pkg::RST_MAX_DUTY);

  int          err_hist [HIST_DEPTH];
  int          err_fill;
  int          err_total;
  logic [31:0] stamp_hist [STREAK_LEN];
  int          stamp_fill;
  int          dev_streak;
  bit          corner_now;

  lsdc_pkg::lsdc_out_t due_words [$];   // result words still owed by the block
  int                  errors;
  int                  stall_cycles;
  int                  send_idle_pct = 21;
  int                  recv_idle_pct = 51;

  // Work out the result word of one frame and advance the mirrored history.
  function automatic lsdc_pkg::lsdc_out_t steer_predict(lsdc_pkg::lsdc_in_t w);
    int                  err, avg, mag, e, offs, i;
    bit                  span_ok;
    int                  speed, left, right;
    lsdc_pkg::lsdc_out_t r;
    err = int'(w.raw_error);

    // Slide the averaging window once it is full; otherwise just append.
    if (err_fill >= HIST_DEPTH) begin
      err_total -= err_hist[0];
      for (i = 0; i < HIST_DEPTH - 1; i++) err_hist[i] = err_hist[i + 1];
      err_hist[HIST_DEPTH - 1] = err;
    end else begin
      err_hist[err_fill] = err;
      err_fill++;
    end
    err_total += err;
    avg = err_total / err_fill;   // truncates toward zero

    // Timestamps: the span is only meaningful once the window is full.
    if (stamp_fill >= STREAK_LEN) begin
      for (i = 0; i < STREAK_LEN - 1; i++) stamp_hist[i] = stamp_hist[i + 1];
      stamp_hist[STREAK_LEN - 1] = w.frame_time_ms;
    end else begin
      stamp_hist[stamp_fill] = w.frame_time_ms;
      stamp_fill++;
    end
    span_ok = 1'b0;
    if (stamp_fill >= STREAK_LEN)
      span_ok = (stamp_hist[STREAK_LEN - 1] - stamp_hist[0]) <= 32'(win_cfg);

    // Saturating run of deviating frames; a calm frame clears the corner flag.
    mag = (err < 0) ? -err : err;
    if (mag > thr_cfg) begin
      if (dev_streak < STREAK_LEN) dev_streak++;
    end else begin
      dev_streak = 0;
    end
    if (dev_streak >= STREAK_LEN && span_ok) corner_now = 1'b1;
    else if (dev_streak == 0) corner_now = 1'b0;

    speed = corner_now ? slow_cfg : base_cfg;
    e = avg;
    if (e > maxerr_cfg) e = maxerr_cfg;
    if (e < -maxerr_cfg) e = -maxerr_cfg;
    offs = (e * gain_cfg) / 256;
    left  = speed - offs;
    right = speed + offs;
    // Upper clamp first, so a minimum above the maximum wins.
    if (left > maxdut_cfg) left = maxdut_cfg;
    if (left < mindut_cfg) left = mindut_cfg;
    if (right > maxdut_cfg) right = maxdut_cfg;
    if (right < mindut_cfg) right = mindut_cfg;

    r.left_duty      = w.lane_found ? left[lsdc_pkg::DUTY_W-1:0] : '0;
    r.right_duty     = w.lane_found ? right[lsdc_pkg::DUTY_W-1:0] : '0;
    r.drive_on       = w.lane_found;
    r.smoothed_error = avg[lsdc_pkg::ERR_W-1:0];
    r.corner_mode    = corner_now;
    return r;
  endfunction

  task automatic flag_field(string field, logic [19:0] want_v, logic [19:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check each result word against the oldest one owed, then log any
  // word taken in the same edge. Everything is sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    lsdc_pkg::lsdc_out_t want;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, got %h", $time, out_word);
        end else begin
          want = due_words[0];
          due_words.delete(0);
          flag_field("left_duty", want.left_duty, out_word.left_duty);
          flag_field("right_duty", want.right_duty, out_word.right_duty);
          flag_field("drive_on", 20'(want.drive_on), 20'(out_word.drive_on));
          flag_field("smoothed_error", 20'(want.smoothed_error),
                     20'(out_word.smoothed_error));
          flag_field("corner_mode", 20'(want.corner_mode), 20'(out_word.corner_mode));
        end
      end
      if (in_valid && in_ready) begin
        // Advance the mirror on every word; typed rows override its answer.
        want = steer_predict(in_word);
        due_words.insert(due_words.size(), word_fixed ? word_want : want);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Give up if nothing moves for far longer than the slowest correct item.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: stall at random, decided afresh at every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [31:0] clock_ms;
  int          burst_left;
  bit          burst_neg;

  // Offer one word, after a random gap, and hold it until taken.
  task automatic send_frame(lsdc_pkg::lsdc_in_t w, logic fixed, lsdc_pkg::lsdc_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_word    <= w;
    word_fixed <= fixed;
    word_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [lsdc_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[lsdc_pkg::CFG_DATA_W-1:0];
    unique case (idx)
      lsdc_pkg::CFG_DEV_THRESHOLD: thr_cfg    = val & 'h7FF;
      lsdc_pkg::CFG_WINDOW_LIMIT:  win_cfg    = val & 'hFFFF;
      lsdc_pkg::CFG_CRUISE_DUTY:   base_cfg   = val & 'hFFFFF;
      lsdc_pkg::CFG_CORNER_DUTY:   slow_cfg   = val & 'hFFFFF;
      lsdc_pkg::CFG_MAX_ERROR:     maxerr_cfg = val & 'h7FF;
      lsdc_pkg::CFG_STEER_GAIN:    gain_cfg   = val & 'h3FF;
      lsdc_pkg::CFG_MIN_DUTY:      mindut_cfg = val & 'hFFFFF;
      lsdc_pkg::CFG_MAX_DUTY:      maxdut_cfg = val & 'hFFFFF;
    endcase
    @(negedge clk);
  endtask

  // Write every register for one setting; only called while the block is idle.
  task automatic load_setting(setting_t kind);
    int v [8];
    case (kind)
      SET_RESET:  v = '{int'(lsdc_pkg::RST_DEV_THRESHOLD), int'(lsdc_pkg::RST_WINDOW_LIMIT),
                        int'(lsdc_pkg::RST_CRUISE_DUTY), int'(lsdc_pkg::RST_CORNER_DUTY),
                        int'(lsdc_pkg::RST_MAX_ERROR), int'(lsdc_pkg::RST_STEER_GAIN),
                        int'(lsdc_pkg::RST_MIN_DUTY), int'(lsdc_pkg::RST_MAX_DUTY)};
      SET_HIGH:   v = '{2047, 65535, 1000000, 1000000, 2047, 1023, 0, 1000000};
      // Everything at the floor, with the duty clamps crossed over.
      SET_LOW:    v = '{0, 0, 0, 0, 0, 0, 1000000, 0};
      default: begin
        v[0] = ($urandom_range(3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 200);
        v[1] = $urandom_range(0, 1200);
        v[2] = $urandom_range(0, 1000000);
        v[3] = $urandom_range(0, 1000000);
        v[4] = $urandom_range(0, 2047);
        v[5] = $urandom_range(0, 1023);
        v[6] = $urandom_range(0, 400000);
        v[7] = $urandom_range(200000, 1000000);
      end
    endcase
    write_reg(lsdc_pkg::CFG_DEV_THRESHOLD, v[0]);
    write_reg(lsdc_pkg::CFG_WINDOW_LIMIT, v[1]);
    write_reg(lsdc_pkg::CFG_CRUISE_DUTY, v[2]);
    write_reg(lsdc_pkg::CFG_CORNER_DUTY, v[3]);
    write_reg(lsdc_pkg::CFG_MAX_ERROR, v[4]);
    write_reg(lsdc_pkg::CFG_STEER_GAIN, v[5]);
    write_reg(lsdc_pkg::CFG_MIN_DUTY, v[6]);
    write_reg(lsdc_pkg::CFG_MAX_DUTY, v[7]);
    cfg_wr_en <= 1'b0;
  endtask

  // Next camera frame: mostly steady frame spacing with bursts of deviating
  // error so that corner mode is reached, plus jumps, wraps and pure noise.
  function automatic lsdc_pkg::lsdc_in_t next_frame();
    lsdc_pkg::lsdc_in_t w;
    int                 pick, mag, calm_max;
    pick = $urandom_range(99);
    if (pick < 3) clock_ms = $urandom;
    else if (pick < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
    else if (pick < 12) clock_ms += $urandom_range(200, 5000);
    else clock_ms += $urandom_range(0, 80);

    if (burst_left == 0 && $urandom_range(99) < 15) begin
      burst_left = $urandom_range(3, 9);
      burst_neg  = ($urandom_range(1) == 1);
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      w.raw_error = 12'($urandom);
    end else if (burst_left > 0) begin
      burst_left--;
      // Only the most negative error can beat the largest threshold.
      if (thr_cfg >= 2047) w.raw_error = -12'sd2048;
      else if (burst_neg) w.raw_error = 12'(-$urandom_range(thr_cfg + 1, 2048));
      else w.raw_error = 12'($urandom_range(thr_cfg + 1, 2047));
    end else begin
      calm_max = (thr_cfg > 2047) ? 2047 : thr_cfg;
      mag = $urandom_range(0, calm_max);
      w.raw_error = 12'($urandom_range(1) ? -mag : mag);
    end
    w.frame_time_ms = clock_ms;
    w.lane_found    = ($urandom_range(99) < 90);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t dir_tab [DIR_N];
    setting_t plan [PHASES];
    int       p, n;

    plan = '{SET_RANDOM, SET_HIGH, SET_RANDOM, SET_LOW, SET_RESET,
             SET_RANDOM, SET_HIGH, SET_RANDOM, SET_RANDOM};

    // Directed rows under the reset registers (threshold 20, window 500 ms).
    dir_tab = '{
      // first frame after reset: no error, straight ahead at base speed
      {12'sd0,     32'd0,    1'b1, 1'b1, 20'd200000, 20'd200000, 1'b1, 12'sd0, 1'b0},
      // no lane: duties and drive off
      {12'sd0,     32'd10,   1'b0, 1'b1, 20'd0, 20'd0, 1'b0, 12'sd0, 1'b0},
      // five deviating frames inside the window: enter corner mode
      {12'sd2047,  32'd20,   1'b1, 1'b0, NO_WANT},
      {12'sd2047,  32'd30,   1'b1, 1'b0, NO_WANT},
      {-12'sd2048, 32'd40,   1'b1, 1'b0, NO_WANT},
      {12'sd2047,  32'd50,   1'b1, 1'b0, NO_WANT},
      {12'sd2047,  32'd60,   1'b1, 1'b0, NO_WANT},
      // run saturates, corner held, lane lost
      {-12'sd2048, 32'd70,   1'b0, 1'b0, NO_WANT},
      {12'sd21,    32'd80,   1'b1, 1'b0, NO_WANT},
      // error on the threshold is calm: leave corner mode
      {12'sd20,    32'd90,   1'b1, 1'b0, NO_WANT},
      // deviating run spread too wide in time: corner flag keeps its value
      {-12'sd21,   32'd4000, 1'b1, 1'b0, NO_WANT},
      {-12'sd2047, 32'd5000, 1'b1, 1'b0, NO_WANT},
      {-12'sd2047, 32'd6000, 1'b1, 1'b0, NO_WANT},
      {-12'sd2047, 32'd7000, 1'b1, 1'b0, NO_WANT},
      {-12'sd2047, 32'd8000, 1'b1, 1'b0, NO_WANT},
      {-12'sd20,   32'd8010, 1'b1, 1'b0, NO_WANT},
      // timestamps wrapping through zero still give a short span
      {12'sd1000,  32'hFFFF_FFF0, 1'b1, 1'b0, NO_WANT},
      {12'sd1000,  32'hFFFF_FFFA, 1'b1, 1'b0, NO_WANT},
      {12'sd1000,  32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT},
      {12'sd1000,  32'h0000_0005, 1'b1, 1'b0, NO_WANT},
      {12'sd1000,  32'h0000_0010, 1'b1, 1'b0, NO_WANT},
      {-12'sd1,    32'h0000_0020, 1'b1, 1'b0, NO_WANT}
    };

    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIR_N; n++)
      send_frame(dir_tab[n].word, dir_tab[n].fixed, dir_tab[n].want);

    clock_ms = 32'd100;
    for (p = 1; p <= PHASES; p++) begin
      // Drain before touching any register.
      in_valid <= 1'b0;
      while (due_words.size() != 0) @(negedge clk);
      load_setting(plan[p - 1]);

      if (p <= 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 51;
      end else if (p <= 6) begin
        send_idle_pct = 51;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      for (n = 0; n < PHASE_FRAMES; n++)
        send_frame(next_frame(), 1'b0, NO_WANT);
    end

    in_valid <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    // Let any stray word surface before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
